/* design/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared constants and types of the key-value table: table size, operation
// codes, the request token that travels along the cell chain and the commit
// bus that writes a new entry.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_DEFINE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef struct packed {
        logic             active;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             hit;
        logic             free_seen;
        logic [IDX_W-1:0] free_idx;
        logic [VAL_W-1:0] value_out;
    } t_token;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_commit;

endpackage

/* design/kvt_cell.sv */
// ----------------------------------------------------------------------------
// kvt_cell
// One entry of the table. Compares the passing request token with its own
// key, updates the token and the entry, and hands the token to the next cell.
// ----------------------------------------------------------------------------
module kvt_cell
    import kvt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_token           i_tok,
    input  t_commit          i_commit,
    output t_token           o_tok
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    t_token           r_tok;
    t_token           n_tok;
    logic             w_match;
    logic             w_commit_here;

    assign w_match       = i_tok.active && !i_tok.hit && r_valid && (r_key == i_tok.key);
    assign w_commit_here = i_commit.we && (i_commit.idx == i_index);

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.hit = 1'b1;
            if (i_tok.op == OP_LOOKUP) begin
                n_tok.value_out = r_value;
            end
        end
        if (i_tok.active && !r_valid && !i_tok.free_seen) begin
            n_tok.free_seen = 1'b1;
            n_tok.free_idx  = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
            if (w_commit_here) begin
                r_valid <= 1'b1;
            end else if (w_match && (i_tok.op == OP_DELETE)) begin
                r_valid <= 1'b0;
            end
        end
        r_tok.op        <= n_tok.op;
        r_tok.key       <= n_tok.key;
        r_tok.value     <= n_tok.value;
        r_tok.hit       <= n_tok.hit;
        r_tok.free_seen <= n_tok.free_seen;
        r_tok.free_idx  <= n_tok.free_idx;
        r_tok.value_out <= n_tok.value_out;
        if (w_commit_here) begin
            r_key   <= i_commit.key;
            r_value <= i_commit.value;
        end else if (w_match && (i_tok.op == OP_DEFINE)) begin
            r_value <= i_tok.value;
        end
    end

    assign o_tok = r_tok;

endmodule

/* design/key_value_table.sv */
// ----------------------------------------------------------------------------
// key_value_table
// Key-value table with unique keys, built as a chain of entry cells through
// which each define, lookup or delete request travels.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                    tuser
//  s_axis    in         key, value               op
//  m_axis    out        value_out                found, full_error
//
//  A request passes the injection register, every cell in turn (one cell per
//  cycle) and the result and output registers before its result can be taken.
//  One request is in the chain at a time; the next is accepted once the
//  previous result has moved to the output register.
//  Reset clears all valid marks at once; no clearing pass is needed.
//  A stalled output holds the finished request and its table write.
// ----------------------------------------------------------------------------
module key_value_table
    import kvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  i_s_axis_tuser,   // op [1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // value_out [31:0]
    output logic [1:0]  o_m_axis_tuser    // found [0], full_error [1]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    t_state           r_state;
    t_token           r_inj;
    t_token           r_res;
    t_token           w_tok [ENTRIES];
    t_commit          w_commit;
    logic             w_accept;
    logic             w_load;
    logic             r_out_valid;
    logic             r_found;
    logic             r_full;
    logic [VAL_W-1:0] r_value_out;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = (r_state == ST_HOLD) && (!r_out_valid || i_m_axis_tready);

    assign w_commit.we    = w_load && (r_res.op == OP_DEFINE) && !r_res.hit && r_res.free_seen;
    assign w_commit.idx   = r_res.free_idx;
    assign w_commit.key   = r_res.key;
    assign w_commit.value = r_res.value;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(g)),
            .i_tok    ((g == 0) ? r_inj : w_tok[(g == 0) ? 0 : g - 1]),
            .i_commit (w_commit),
            .o_tok    (w_tok[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inj       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inj.active <= w_accept;
            if (w_accept) begin
                r_inj.op        <= i_s_axis_tuser;
                r_inj.key       <= i_s_axis_tdata[31:0];
                r_inj.value     <= i_s_axis_tdata[63:32];
                r_inj.hit       <= 1'b0;
                r_inj.free_seen <= 1'b0;
                r_inj.free_idx  <= '0;
                r_inj.value_out <= '0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_tok[ENTRIES-1].active) begin
                        r_res   <= w_tok[ENTRIES-1];
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_load) begin
                        r_found     <= r_res.hit && (r_res.op != OP_UNUSED);
                        r_full      <= (r_res.op == OP_DEFINE) && !r_res.hit
                                       && !r_res.free_seen;
                        r_value_out <= (r_res.op == OP_LOOKUP && r_res.hit)
                                       ? r_res.value_out : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_value_out;
    assign o_m_axis_tuser  = {r_full, r_found};

endmodule

/* design/kvt_checker.sv */
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks of the key-value table, bound to the top level.
// ----------------------------------------------------------------------------
module kvt_checker
    import kvt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    logic w_s_acc;

    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // The chain holds one request until it has passed every cell.
    a_busy_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |-> ##ENTRIES !o_s_axis_tready)
        else $error("request accepted before the chain was clear");

    a_busy_next : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_axis_tready)
        else $error("request accepted in the cycle after a transaction");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    a_full_miss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> !o_m_axis_tuser[0])
        else $error("full flag raised on a present key");

    a_value_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata != 32'd0)) |-> o_m_axis_tuser[0])
        else $error("value returned without a hit");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);

/* bench/key_value_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_tb
// Self-checking bench for the key-value table. Define, lookup, delete and
// unused-code requests are streamed in, and a shadow copy of the table
// predicts every reply. Each returned transaction is checked against the
// oldest prediction. Directed requests cover misses, overwrites and a full
// table. Random traffic over small key pools follows, with idle bursts on
// both sides and a long output stall.
// ----------------------------------------------------------------------------
module key_value_table_tb;
    import kvt_pkg::*;

    localparam int POOL_MAX   = 32;
    localparam int LONG_STALL = 300;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value_out;
        logic             full_error;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [63:0]       i_s_axis_tdata = '0;
    logic [1:0]        i_s_axis_tuser = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [31:0]       o_m_axis_tdata;
    logic [1:0]        o_m_axis_tuser;

    logic [KEY_W-1:0]  shadow_key   [ENTRIES];
    logic [VAL_W-1:0]  shadow_value [ENTRIES];
    logic              shadow_valid [ENTRIES];
    logic [KEY_W-1:0]  key_pool     [POOL_MAX];
    t_reply            replies_due[$];
    int                mismatches = 0;
    int                stall_requests = 0;
    bit                bursts_on = 1'b0;

    key_value_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_reply table_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] value);
        t_reply reply;
        int     hit;
        int     slot;
        reply = '0;
        hit = -1;
        slot = -1;
        if (op == OP_UNUSED) begin
            return reply;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key) begin
                hit = i;
            end
            if (slot < 0 && !shadow_valid[i]) begin
                slot = i;
            end
        end
        reply.found = (hit >= 0);
        if (op == OP_DEFINE) begin
            if (hit >= 0) begin
                shadow_value[hit] = value;
            end else if (slot >= 0) begin
                shadow_key[slot] = key;
                shadow_value[slot] = value;
                shadow_valid[slot] = 1'b1;
            end else begin
                reply.full_error = 1'b1;
            end
        end else if (op == OP_LOOKUP) begin
            if (hit >= 0) begin
                reply.value_out = shadow_value[hit];
            end
        end else if (hit >= 0) begin
            shadow_valid[hit] = 1'b0;
        end
        return reply;
    endfunction

    task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] value);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {value, key};
        i_s_axis_tuser <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        replies_due.insert(replies_due.size(), table_apply(op, key, value));
    endtask

    task automatic send_random(int pool_size);
        int                pick;
        logic [KEY_W-1:0]  key;
        logic [OP_W-1:0]   op;
        pick = $urandom_range(0, 19);
        key = ($urandom_range(0, 7) == 0) ? $urandom()
                                          : key_pool[$urandom_range(0, pool_size - 1)];
        if (pick < 8) begin
            op = OP_DEFINE;
        end else if (pick < 14) begin
            op = OP_LOOKUP;
        end else if (pick < 19) begin
            op = OP_DELETE;
        end else begin
            op = OP_UNUSED;
        end
        send_request(op, key, $urandom());
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
    endtask

    task automatic test_single_entry_ops();
        send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_DEFINE, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_DEFINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_DEFINE, 32'h0000_0000, 32'h5A5A_A5A5);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        wait_drained();
    endtask

    // One entry is already in use, so the defines below leave no entry free.
    task automatic test_table_full();
        for (int i = 0; i < ENTRIES - 1; i++) begin
            send_request(OP_DEFINE, 32'hC0DE_0000 | i, $urandom());
        end
        send_request(OP_DEFINE, 32'h1234_5678, 32'h8765_4321);
        send_request(OP_DEFINE, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_drained();
    endtask

    task automatic test_random_traffic(int count, int pool_size);
        for (int i = 0; i < pool_size; i++) begin
            key_pool[i] = $urandom();
        end
        repeat (count) send_random(pool_size);
        wait_drained();
    endtask

    task automatic test_output_stall();
        stall_requests++;
        repeat (12) send_random(8);
        wait_drained();
    endtask

    initial begin : sink_ready
        int stall_left;
        int hold_left;
        int stalls_served;
        stall_left = 0;
        hold_left = 0;
        stalls_served = 0;
        forever begin
            @(posedge i_clk);
            if (stalls_served != stall_requests) begin
                stalls_served = stall_requests;
                hold_left = LONG_STALL;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.found = o_m_axis_tuser[0];
            got.value_out = o_m_axis_tdata;
            got.full_error = o_m_axis_tuser[1];
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected reply: found=%0b value=%h full=%0b",
                             got.found, got.value_out, got.full_error);
                end
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch: expected found=%0b value=%h full=%0b, ",
                                  "got found=%0b value=%h full=%0b"},
                                 want.found, want.value_out, want.full_error,
                                 got.found, got.value_out, got.full_error);
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("key_value_table_tb NOT OK");
        $finish;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        bursts_on = 1'b1;
        test_single_entry_ops();
        test_table_full();
        test_random_traffic(600, 6);
        test_output_stall();
        test_random_traffic(600, 28);
        bursts_on = 1'b0;
        test_random_traffic(480, 20);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("key_value_table_tb OK");
        end else begin
            $display("key_value_table_tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/kvt_pkg.sv
design/kvt_cell.sv
design/key_value_table.sv
design/kvt_checker.sv
bench/key_value_table_tb.sv
